FILE: design/unsd_pkg.sv
// Shared types, codes and constants of the UBX/NMEA stream dispatcher.
`default_nettype none

package unsd_pkg;

	// Defaults and fixed widths.
	localparam int BUFFER_BYTES_DEF = 256;
	localparam int LEN_W            = 9;
	localparam int CFG_IDX_W        = 1;
	localparam int Q_DEPTH          = 2;
	localparam int QCNT_W           = $clog2(Q_DEPTH + 1);

	localparam logic [7:0] SYNC_BYTE_RST     = 8'd181;
	localparam logic [7:0] LINE_END_BYTE_RST = 8'd10;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_SYNC_BYTE     = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_LINE_END_BYTE = 1'b1;

	// Stream kind codes.
	localparam logic [1:0] KIND_NONE  = 2'd0;
	localparam logic [1:0] KIND_UBX   = 2'd1;
	localparam logic [1:0] KIND_ASCII = 2'd2;

	// Status codes.
	localparam logic [2:0] ST_BUSY      = 3'd0;
	localparam logic [2:0] ST_GOOD      = 3'd1;
	localparam logic [2:0] ST_UBX_CSUM  = 3'd2;
	localparam logic [2:0] ST_NMEA_ERR  = 3'd3;
	localparam logic [2:0] ST_BAD_CHAR  = 3'd4;
	localparam logic [2:0] ST_OVERRUN   = 3'd5;

	typedef struct packed {
		logic       cmd;
		logic [7:0] rx_byte;
	} req_t;

	typedef struct packed {
		logic [7:0]       out_byte;
		logic [1:0]       stream_kind;
		logic             frame_end;
		logic [2:0]       status;
		logic [LEN_W-1:0] frame_length;
		logic [7:0]       msg_class;
		logic [7:0]       msg_id;
	} rsp_t;

	// Per-byte character flags used by the NMEA checksum check.
	typedef struct packed {
		logic       is_star;
		logic       hex_ok;
		logic [3:0] hex_val;
	} tag_t;

	// A classified request as it travels through the queue.
	typedef struct packed {
		logic       cmd;
		logic [7:0] rx_byte;
		logic       is_sync;
		logic       is_ascii;
		logic       is_line_end;
		tag_t       tag;
	} item_t;

	typedef struct packed {
		logic              empty;
		logic              full;
	} q_stat_t;

endpackage

`default_nettype wire

FILE: design/unsd_front.sv
// Front end: accepts requests and classifies each received byte.
`default_nettype none

module unsd_front import unsd_pkg::*; (
	input  wire logic  req_valid,
	output logic       req_ready,
	input  wire req_t  req,
	input  wire logic [7:0] sync_byte,
	input  wire logic [7:0] line_end_byte,
	input  wire q_stat_t q_stat,
	output logic       push,
	output item_t      push_item
);

	localparam logic [7:0] CHAR_STAR = 8'h2a;

	logic [7:0] b;

	assign b         = req.rx_byte;
	assign req_ready = !q_stat.full;
	assign push      = req_valid && req_ready;

	always_comb begin
		push_item             = '0;
		push_item.cmd         = req.cmd;
		push_item.rx_byte     = b;
		push_item.is_sync     = (b == sync_byte);
		push_item.is_ascii    = !b[7];
		push_item.is_line_end = (b == line_end_byte);
		push_item.tag.is_star = (b == CHAR_STAR);
		// Hex digit decode for the checksum characters.
		if (b >= 8'h30 && b <= 8'h39) begin
			push_item.tag.hex_ok  = 1'b1;
			push_item.tag.hex_val = b[3:0];
		end else if ((b >= 8'h41 && b <= 8'h46) || (b >= 8'h61 && b <= 8'h66)) begin
			push_item.tag.hex_ok  = 1'b1;
			push_item.tag.hex_val = b[3:0] + 4'd9;
		end
	end

endmodule

`default_nettype wire

FILE: design/unsd_queue.sv
// Short queue of classified requests between front end and parser.
`default_nettype none

module unsd_queue import unsd_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	input  wire item_t push_item,
	input  wire logic  pop,
	output item_t      pop_item,
	output q_stat_t    stat
);

	localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;

	item_t             entry_q [Q_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		ptr_inc = (p == PTR_W'(Q_DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	assign pop_item    = entry_q[rd_ptr_q];
	assign stat.empty  = (count_q == '0);
	assign stat.full   = (count_q == QCNT_W'(Q_DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

`default_nettype wire

FILE: design/unsd_back.sv
// Back end: frame parser with running checksums and the result register.
`default_nettype none

module unsd_back import unsd_pkg::*; #(
	parameter int BUFFER_BYTES = BUFFER_BYTES_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  q_valid,
	output logic       pop,
	input  wire item_t item,
	output logic       rsp_valid,
	input  wire logic  rsp_ready,
	output rsp_t       rsp
);

	localparam int CNT_W = $clog2(BUFFER_BYTES + 1);

	localparam logic [CNT_W-1:0] POS_CLASS  = CNT_W'(2);
	localparam logic [CNT_W-1:0] POS_ID     = CNT_W'(3);
	localparam logic [CNT_W-1:0] POS_LEN_LO = CNT_W'(4);
	localparam logic [CNT_W-1:0] POS_LEN_HI = CNT_W'(5);
	localparam logic [CNT_W-1:0] POS_BODY   = CNT_W'(6);
	localparam logic [CNT_W-1:0] MIN_LINE   = CNT_W'(5);
	localparam logic [CNT_W-1:0] CNT_LIMIT  = CNT_W'(BUFFER_BYTES);

	typedef enum logic [1:0] {
		MODE_IDLE,
		MODE_UBX,
		MODE_ASCII
	} mode_t;

	mode_t            mode_q, mode_n, mode_eff;
	logic [CNT_W-1:0] cnt_q, cnt_n, idx, cnt1;
	logic [15:0]      pl_q, pl_n;
	logic [7:0]       fa_q, fa_n, fb_q, fb_n, xor_q, xor_n;
	logic [3:0][7:0]  rb_q, rb_n;
	tag_t [3:0]       rt_q, rt_n;
	logic [7:0]       cls_q, cls_n, id_q, id_n, lenlo_q, lenlo_n;
	logic             start;
	logic [7:0]       b;
	rsp_t             res;
	rsp_t             rsp_q;
	logic             rsp_valid_q;
	logic             line_good;

	assign b         = item.rx_byte;
	assign rsp       = rsp_q;
	assign rsp_valid = rsp_valid_q;
	assign pop       = q_valid && (!rsp_valid_q || rsp_ready);

	always_comb begin
		mode_n   = mode_q;
		mode_eff = mode_q;
		cnt_n    = cnt_q;
		pl_n     = pl_q;
		fa_n     = fa_q;
		fb_n     = fb_q;
		xor_n    = xor_q;
		rb_n     = rb_q;
		rt_n     = rt_q;
		cls_n    = cls_q;
		id_n     = id_q;
		lenlo_n  = lenlo_q;
		start    = 1'b0;
		idx      = '0;
		cnt1     = '0;
		line_good = 1'b0;
		res          = '0;
		res.out_byte = b;

		if (item.cmd) begin
			start  = 1'b1;
			mode_n = MODE_IDLE;
		end else if (mode_q == MODE_IDLE) begin
			if (item.is_sync) begin
				mode_eff = MODE_UBX;
				start    = 1'b1;
			end else if (item.is_ascii) begin
				mode_eff = MODE_ASCII;
				start    = 1'b1;
			end else begin
				res.status = ST_BAD_CHAR;
			end
		end

		if (start) begin
			cnt_n   = '0;
			pl_n    = '0;
			fa_n    = '0;
			fb_n    = '0;
			xor_n   = '0;
			rb_n    = '0;
			rt_n    = '0;
			cls_n   = '0;
			id_n    = '0;
			lenlo_n = '0;
		end

		if (!item.cmd && mode_eff != MODE_IDLE) begin
			mode_n           = mode_eff;
			idx              = cnt_n;
			cnt1             = cnt_n + CNT_W'(1);
			cnt_n            = cnt1;
			res.frame_length = LEN_W'(cnt1);
			if (mode_eff == MODE_UBX) begin
				res.stream_kind = KIND_UBX;
				case (idx)
					POS_CLASS:  cls_n   = b;
					POS_ID:     id_n    = b;
					POS_LEN_LO: lenlo_n = b;
					POS_LEN_HI: pl_n    = {b, lenlo_n};
					default: ;
				endcase
				// Checksum covers class, id, length and payload only.
				if (idx >= POS_CLASS && (idx < POS_BODY ||
						17'(idx) < {1'b0, pl_n} + 17'd6)) begin
					fa_n = fa_n + b;
					fb_n = fb_n + fa_n;
				end
				res.msg_class = cls_n;
				res.msg_id    = id_n;
				if (cnt1 >= CNT_LIMIT) begin
					res.frame_end = 1'b1;
					res.status    = ST_OVERRUN;
					mode_n        = MODE_IDLE;
				end else if (idx >= POS_BODY && 17'(cnt1) == {1'b0, pl_n} + 17'd8) begin
					res.frame_end = 1'b1;
					res.status    = (rb_n[0] == fa_n && b == fb_n) ? ST_GOOD : ST_UBX_CSUM;
					mode_n        = MODE_IDLE;
				end
			end else begin
				res.stream_kind = KIND_ASCII;
				// Good line: '*' then two hex digits matching the running XOR,
				// followed by one more character before the line end.
				line_good = (cnt1 >= MIN_LINE) && rt_n[3].is_star && rt_n[2].hex_ok &&
					rt_n[1].hex_ok && ({rt_n[2].hex_val, rt_n[1].hex_val} == xor_n);
				if (cnt1 >= CNT_LIMIT) begin
					res.frame_end = 1'b1;
					res.status    = ST_OVERRUN;
					mode_n        = MODE_IDLE;
				end else if (item.is_line_end) begin
					res.frame_end = 1'b1;
					res.status    = line_good ? ST_GOOD : ST_NMEA_ERR;
					mode_n        = MODE_IDLE;
				end else if (idx >= MIN_LINE) begin
					xor_n = xor_n ^ rb_n[3];
				end
			end
			rb_n = {rb_n[2:0], b};
			rt_n = {rt_n[2:0], item.tag};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_IDLE;
			cnt_q       <= '0;
			pl_q        <= '0;
			fa_q        <= '0;
			fb_q        <= '0;
			xor_q       <= '0;
			rb_q        <= '0;
			rt_q        <= '0;
			cls_q       <= '0;
			id_q        <= '0;
			lenlo_q     <= '0;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else begin
			if (pop) begin
				mode_q      <= mode_n;
				cnt_q       <= cnt_n;
				pl_q        <= pl_n;
				fa_q        <= fa_n;
				fb_q        <= fb_n;
				xor_q       <= xor_n;
				rb_q        <= rb_n;
				rt_q        <= rt_n;
				cls_q       <= cls_n;
				id_q        <= id_n;
				lenlo_q     <= lenlo_n;
				rsp_q       <= res;
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

FILE: design/ubx_nmea_stream_dispatcher.sv
// Top level of the UBX/NMEA stream dispatcher: config registers and the three parts.
`default_nettype none

// Channel | Handshake             | Payload                     | Direction
// --------+-----------------------+-----------------------------+----------
// req     | req_valid / req_ready | req_t  (cmd, rx_byte)       | in
// rsp     | rsp_valid / rsp_ready | rsp_t  (one per request)    | out
// cfg     | cfg_valid / cfg_ready | cfg_index, cfg_data         | in
//
// Sustained rate is one request per clock while rsp_ready stays high; the parser
// updates all of its running sums and counters for each byte at once.
// A classified byte is first written into the queue, and the parser then takes
// it from there into the result register.
// The two-entry queue lets requests keep coming while a result is stalled;
// req_ready drops only when the queue is full.
// Reset is asynchronous and leaves the parser idle with the default sync
// (0xB5) and line end (LF) bytes; there is no clearing pass.
module ubx_nmea_stream_dispatcher import unsd_pkg::*; #(
	parameter int BUFFER_BYTES = BUFFER_BYTES_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 req_valid,
	output logic                      req_ready,
	input  wire req_t                 req,
	output logic                      rsp_valid,
	input  wire logic                 rsp_ready,
	output rsp_t                      rsp,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [7:0]           cfg_data
);

	logic [7:0] sync_byte_q;
	logic [7:0] line_end_byte_q;
	logic       push;
	item_t      push_item;
	logic       pop;
	item_t      pop_item;
	q_stat_t    q_stat;

	// Configuration writes are always taken; the user must write only while the block is idle, which it does not enforce.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_byte_q     <= SYNC_BYTE_RST;
			line_end_byte_q <= LINE_END_BYTE_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_SYNC_BYTE:     sync_byte_q     <= cfg_data;
				REG_LINE_END_BYTE: line_end_byte_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// The front end compares each byte against the configured sync and line
	// end values and decodes star and hex digits, so the parser sees flags beside the byte.
	unsd_front u_front (
		.req_valid     (req_valid),
		.req_ready     (req_ready),
		.req           (req),
		.sync_byte     (sync_byte_q),
		.line_end_byte (line_end_byte_q),
		.q_stat        (q_stat),
		.push          (push),
		.push_item     (push_item)
	);

	unsd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.pop_item  (pop_item),
		.stat      (q_stat)
	);

	// The parser takes one queued byte whenever its result register is free
	// or being emptied in the same cycle.
	unsd_back #(
		.BUFFER_BYTES (BUFFER_BYTES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (!q_stat.empty),
		.pop       (pop),
		.item      (pop_item),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	// A request taken into an empty queue must be present there next cycle.
	a_push_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready && q_stat.empty) |=> !q_stat.empty)
		else $error("accepted request did not reach the queue");

	// With work queued and the result register empty, a result must follow.
	a_back_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(!q_stat.empty && !rsp_valid) |=> rsp_valid)
		else $error("parser did not take queued work");

	// An end mark only ever belongs to a UBX or ASCII byte.
	a_end_has_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.frame_end) |-> (rsp.stream_kind != KIND_NONE))
		else $error("frame end on a dropped byte");

	// A dropped byte carries no frame context.
	a_bad_char_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.status == ST_BAD_CHAR) |->
		(rsp.stream_kind == KIND_NONE && rsp.frame_length == '0 && !rsp.frame_end))
		else $error("bad char result carries frame fields");

endmodule

`default_nettype wire
